// ===== rtl/genotype_emission_accumulator_defines.svh =====
// Assertion macros for the genotype emission accumulator checker.
`ifndef GENOTYPE_EMISSION_ACCUMULATOR_DEFINES_SVH
`define GENOTYPE_EMISSION_ACCUMULATOR_DEFINES_SVH

// Implication to the next cycle, off while reset is low.
`define GEA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("gea check failed");

// Implication to the next cycle, also checked through reset.
`define GEA_ASSERT_NEXT_ALL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("gea check failed");

`endif

// ===== rtl/gea_pkg.sv =====
// Shared types and constants of the genotype emission accumulator.
`default_nettype none
package gea_pkg;
    localparam int NGENO    = 10;
    localparam int PQ       = 30;
    localparam int LOG_FRAC = 20;
    localparam int MUL_W    = 34;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] RECIP3  = 32'hAAAAAAAB;

    localparam logic [3:0] G_AA = 4'd0;
    localparam logic [3:0] G_CC = 4'd1;
    localparam logic [3:0] G_GG = 4'd2;
    localparam logic [3:0] G_TT = 4'd3;
    localparam logic [3:0] G_AC = 4'd4;
    localparam logic [3:0] G_AG = 4'd5;
    localparam logic [3:0] G_AT = 4'd6;
    localparam logic [3:0] G_CG = 4'd7;
    localparam logic [3:0] G_CT = 4'd8;
    localparam logic [3:0] G_GT = 4'd9;
    localparam logic [3:0] GENO_LAST = G_GT;

    localparam logic [1:0] B_A = 2'd0;
    localparam logic [1:0] B_C = 2'd1;
    localparam logic [1:0] B_G = 2'd2;
    localparam logic [1:0] B_T = 2'd3;

    typedef logic [4:0] t_op;
    localparam t_op OP_NOP    = 5'd0;
    localparam t_op OP_LOAD   = 5'd1;
    localparam t_op OP_E3     = 5'd2;
    localparam t_op OP_DOM    = 5'd3;
    localparam t_op OP_DE3    = 5'd4;
    localparam t_op OP_PROB   = 5'd5;
    localparam t_op OP_PHI    = 5'd6;
    localparam t_op OP_PLO    = 5'd7;
    localparam t_op OP_PFIN   = 5'd8;
    localparam t_op OP_LZERO  = 5'd9;
    localparam t_op OP_LSTART = 5'd10;
    localparam t_op OP_NORM   = 5'd11;
    localparam t_op OP_SQ     = 5'd12;
    localparam t_op OP_SQFIX  = 5'd13;
    localparam t_op OP_LN     = 5'd14;
    localparam t_op OP_LADD   = 5'd15;
    localparam t_op OP_EMIT   = 5'd16;

    typedef logic [30:0] t_prob;

    typedef struct packed {
        t_op        op;
        logic [3:0] geno;
        logic [4:0] bit_idx;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic last;
        logic p_zero;
        logic norm_done;
        logic out_block;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/gea_ctrl.sv =====
// Sequencer of the genotype emission accumulator.
`default_nettype none
module gea_ctrl import gea_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_E3     = 4'd1;
    localparam logic [3:0] S_DOM    = 4'd2;
    localparam logic [3:0] S_DE3    = 4'd3;
    localparam logic [3:0] S_PROB   = 4'd4;
    localparam logic [3:0] S_GSTART = 4'd5;
    localparam logic [3:0] S_PLO    = 4'd6;
    localparam logic [3:0] S_PFIN   = 4'd7;
    localparam logic [3:0] S_NORM   = 4'd8;
    localparam logic [3:0] S_SQ     = 4'd9;
    localparam logic [3:0] S_SQFIX  = 4'd10;
    localparam logic [3:0] S_LN     = 4'd11;
    localparam logic [3:0] S_LADD   = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    logic [3:0] r_state, n_state;
    logic [3:0] r_geno, n_geno;
    logic [4:0] r_iter, n_iter;
    logic       adv;

    always_comb begin
        n_state = r_state;
        n_geno  = r_geno;
        n_iter  = r_iter;
        adv     = 1'b0;
        o_cmd.op      = OP_NOP;
        o_cmd.geno    = r_geno;
        o_cmd.bit_idx = r_iter;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_E3;
                end
            end
            S_E3: begin
                o_cmd.op = OP_E3;
                n_state  = S_DOM;
            end
            S_DOM: begin
                o_cmd.op = OP_DOM;
                n_state  = S_DE3;
            end
            S_DE3: begin
                o_cmd.op = OP_DE3;
                n_state  = S_PROB;
            end
            S_PROB: begin
                o_cmd.op = OP_PROB;
                n_geno   = G_AA;
                n_state  = S_GSTART;
            end
            S_GSTART: begin
                if (!i_status.mode) begin
                    o_cmd.op = OP_PHI;
                    n_state  = S_PLO;
                end else if (i_status.p_zero) begin
                    o_cmd.op = OP_LZERO;
                    adv      = 1'b1;
                end else begin
                    o_cmd.op = OP_LSTART;
                    n_iter   = 5'(LOG_FRAC - 1);
                    n_state  = S_NORM;
                end
            end
            S_PLO: begin
                o_cmd.op = OP_PLO;
                n_state  = S_PFIN;
            end
            S_PFIN: begin
                o_cmd.op = OP_PFIN;
                adv      = 1'b1;
            end
            S_NORM: begin
                if (i_status.norm_done) begin
                    o_cmd.op = OP_SQ;
                    n_state  = S_SQFIX;
                end else begin
                    o_cmd.op = OP_NORM;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_SQFIX;
            end
            S_SQFIX: begin
                o_cmd.op = OP_SQFIX;
                if (r_iter == 5'd0) begin
                    n_state = S_LN;
                end else begin
                    n_iter  = r_iter - 5'd1;
                    n_state = S_SQ;
                end
            end
            S_LN: begin
                o_cmd.op = OP_LN;
                n_state  = S_LADD;
            end
            S_LADD: begin
                o_cmd.op = OP_LADD;
                adv      = 1'b1;
            end
            S_EMIT: begin
                if (!i_status.out_block) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (adv) begin
            if (r_geno == GENO_LAST) begin
                n_state = i_status.last ? S_EMIT : S_IDLE;
            end else begin
                n_geno  = r_geno + 4'd1;
                n_state = S_GSTART;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_geno  <= G_AA;
            r_iter  <= 5'd0;
        end else begin
            r_state <= n_state;
            r_geno  <= n_geno;
            r_iter  <= n_iter;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/gea_datapath.sv =====
// Datapath: probabilities, shared multiplier, log unit, score registers.
`default_nettype none
module gea_datapath import gea_pkg::*; #(
    parameter int SCORE_WIDTH    = 32,
    parameter int PROB_FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_score_mode_we,
    input  wire         i_score_mode,
    input  wire  [1:0]  i_base_code,
    input  wire  [15:0] i_error_rate,
    input  wire  [15:0] i_damage_g_to_a,
    input  wire  [15:0] i_damage_c_to_t,
    input  wire         i_start_site,
    input  wire         i_last_of_site,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  wire         i_out_stall,
    output logic        o_out_valid,
    output logic [31:0] o_score [NGENO],
    output logic        o_saturated
);
    localparam int W = SCORE_WIDTH;
    localparam int F = PROB_FRAC_BITS;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] SCORE_ONE = (W > PQ + 1) ? W'(64'd1 << PQ) : SMAX;
    localparam logic [15:0] RMASK = (F >= 16) ? 16'hFFFF : 16'((32'd1 << F) - 32'd1);

    logic               r_mode;
    logic [1:0]         r_base;
    logic               r_last;
    logic [15:0]        r_e;
    logic [15:0]        r_d;
    t_prob              r_e3;
    logic [59:0]        r_p1;
    t_prob              r_p [NGENO];
    logic signed [W-1:0] r_score [NGENO];
    logic               r_sat;
    logic [67:0]        r_mul;
    logic [64:0]        r_hi;
    logic [31:0]        r_x;
    logic [4:0]         r_cnt;
    logic [LOG_FRAC-1:0] r_frac;
    logic               r_lneg;
    logic               r_out_valid;
    logic [31:0]        r_out_score [NGENO];
    logic               r_out_sat;

    logic [29:0]  e30;
    logic [31:0]  om_w;
    t_prob        om;
    t_prob        p_g;
    logic signed [W-1:0] s_g;
    logic [63:0]  s64, mag64;
    logic [59:0]  e3s, oms, p2, m_a, m_b, m_c, m_d, m_e;
    t_prob        p_a, p_b, p_c, p_d, p_e, hme;
    t_prob        n_p [NGENO];
    logic [MUL_W-1:0] mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic [65:0]  r_sum;
    logic         pz;
    logic signed [W-1:0] pfin_val;
    logic         pfin_sat;
    logic [5:0]   int_part;
    logic [25:0]  l2, lmag;
    logic [58:0]  rnd;
    logic signed [23:0] lnv;
    logic signed [W:0]  lsum;
    logic signed [W-1:0] ladd_val;
    logic         ladd_sat;
    logic [32:0]  sq;

    assign e30  = 30'(r_e) << (PQ - F);
    assign om_w = ((32'd1 << F) - 32'(r_e)) << (PQ - F);
    assign om   = om_w[30:0];
    assign p_g  = r_p[i_cmd.geno];
    assign s_g  = r_score[i_cmd.geno];
    assign s64  = 64'(s_g);
    assign mag64 = s_g[W-1] ? (64'd0 - s64) : s64;

    // mixes: A = nd*e3+d*om, B = nd*om+d*e3, C = (1+d)*om+nd*e3,
    // D = d*om+(2-d)*e3, E = nd*om+(1+d)*e3
    assign e3s = 60'(r_e3) << F;
    assign oms = 60'(om) << F;
    assign p2  = r_mul[59:0];
    assign m_a = e3s + r_p1 - p2;
    assign m_b = oms - r_p1 + p2;
    assign m_c = oms + r_p1 + e3s - p2;
    assign m_d = r_p1 + (e3s << 1) - p2;
    assign m_e = oms - r_p1 + e3s + p2;
    assign p_a = t_prob'(m_a >> F);
    assign p_b = t_prob'(m_b >> F);
    assign p_c = t_prob'(m_c >> (F + 1));
    assign p_d = t_prob'(m_d >> (F + 1));
    assign p_e = t_prob'(m_e >> (F + 1));
    assign hme = 31'(32'd1 << (PQ - 1)) - r_e3;

    always_comb begin
        for (int i = 0; i < NGENO; i++) begin
            n_p[i] = r_e3;
        end
        unique case (r_base)
            B_A: begin
                n_p[G_AA] = om;
                n_p[G_GG] = p_a;
                n_p[G_AC] = hme;
                n_p[G_AG] = p_c;
                n_p[G_AT] = hme;
                n_p[G_CG] = p_d;
                n_p[G_GT] = p_d;
            end
            B_C: begin
                n_p[G_CC] = p_b;
                n_p[G_AC] = p_e;
                n_p[G_CG] = p_e;
                n_p[G_CT] = p_e;
            end
            B_G: begin
                n_p[G_GG] = p_b;
                n_p[G_AG] = p_e;
                n_p[G_CG] = p_e;
                n_p[G_GT] = p_e;
            end
            B_T: begin
                n_p[G_CC] = p_a;
                n_p[G_TT] = om;
                n_p[G_AT] = hme;
                n_p[G_AC] = p_d;
                n_p[G_CG] = p_d;
                n_p[G_CT] = p_c;
                n_p[G_GT] = hme;
            end
            default: ;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_E3: begin
                mul_a = MUL_W'(e30);
                mul_b = MUL_W'(RECIP3);
            end
            OP_DOM: begin
                mul_a = MUL_W'(r_d);
                mul_b = MUL_W'(om);
            end
            OP_DE3: begin
                mul_a = MUL_W'(r_d);
                mul_b = MUL_W'(r_e3);
            end
            OP_PHI: begin
                mul_a = mag64[63:30];
                mul_b = MUL_W'(p_g);
            end
            OP_PLO: begin
                mul_a = MUL_W'(mag64[29:0]);
                mul_b = MUL_W'(p_g);
            end
            OP_SQ: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_x);
            end
            OP_LN: begin
                mul_a = MUL_W'(lmag);
                mul_b = MUL_W'(LN2_Q32);
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // product fold, truncated toward zero
    assign r_sum = 66'(r_hi) + 66'(r_mul[60:30]);
    assign pz    = (r_sum == 66'd0);
    always_comb begin
        pfin_sat = (mag64 != 64'd0) && (p_g != '0) && pz;
        if (pz) begin
            pfin_val = '0;
        end else if (s_g[W-1]) begin
            pfin_val = W'(66'd0 - r_sum);
        end else if (r_sum > 66'(SMAX)) begin
            pfin_val = SMAX;
            pfin_sat = 1'b1;
        end else begin
            pfin_val = W'(r_sum);
        end
    end

    // log2 in Q.20, then times ln2 with floor
    assign int_part = 6'd1 - {1'b0, r_cnt};
    assign l2       = {int_part, r_frac};
    assign lmag     = l2[25] ? (26'd0 - l2) : l2;
    assign rnd      = {1'b0, r_mul[57:0]} + {23'd0, {36{r_lneg}}};
    assign lnv      = r_lneg ? -$signed({1'b0, rnd[58:36]}) : $signed({1'b0, rnd[58:36]});
    assign lsum     = (W+1)'(s_g) + (W+1)'(lnv);
    always_comb begin
        ladd_sat = 1'b0;
        if (lsum > (W+1)'(SMAX)) begin
            ladd_val = SMAX;
            ladd_sat = 1'b1;
        end else if (lsum < (W+1)'(SMIN)) begin
            ladd_val = SMIN;
            ladd_sat = 1'b1;
        end else begin
            ladd_val = W'(lsum);
        end
    end
    assign sq = r_mul[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b1;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NGENO; i++) begin
                r_score[i] <= '0;
            end
        end else begin
            if (i_score_mode_we) begin
                r_mode <= i_score_mode;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    if (i_start_site) begin
                        for (int i = 0; i < NGENO; i++) begin
                            r_score[i] <= r_mode ? '0 : SCORE_ONE;
                        end
                        r_sat <= 1'b0;
                    end
                end
                OP_LZERO: begin
                    r_score[i_cmd.geno] <= SMIN;
                    r_sat <= 1'b1;
                end
                OP_PFIN: begin
                    r_score[i_cmd.geno] <= pfin_val;
                    if (pfin_sat) begin
                        r_sat <= 1'b1;
                    end
                end
                OP_LADD: begin
                    r_score[i_cmd.geno] <= ladd_val;
                    if (ladd_sat) begin
                        r_sat <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= mul_p;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_base <= i_base_code;
                r_last <= i_last_of_site;
                r_e    <= i_error_rate & RMASK;
                r_d    <= ((i_base_code == B_A || i_base_code == B_G) ?
                           i_damage_g_to_a : i_damage_c_to_t) & RMASK;
            end
            OP_DOM:  r_e3 <= t_prob'(r_mul[62:33]);
            OP_DE3:  r_p1 <= r_mul[59:0];
            OP_PROB: r_p  <= n_p;
            OP_PLO:  r_hi <= r_mul[64:0];
            OP_LSTART: begin
                r_x    <= {1'b0, p_g};
                r_cnt  <= 5'd0;
                r_frac <= '0;
            end
            OP_NORM: begin
                r_x   <= r_x << 1;
                r_cnt <= r_cnt + 5'd1;
            end
            OP_SQFIX: begin
                if (sq[32]) begin
                    r_x <= sq[32:1];
                    r_frac[i_cmd.bit_idx] <= 1'b1;
                end else begin
                    r_x <= sq[31:0];
                end
            end
            OP_LN: r_lneg <= l2[25];
            OP_EMIT: begin
                for (int i = 0; i < NGENO; i++) begin
                    r_out_score[i] <= 32'(r_score[i]);
                end
                r_out_sat <= r_sat;
            end
            default: ;
        endcase
    end

    assign o_status.mode      = r_mode;
    assign o_status.last      = r_last;
    assign o_status.p_zero    = (p_g == '0);
    assign o_status.norm_done = r_x[31];
    assign o_status.out_block = r_out_valid & i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_score            = r_out_score;
    assign o_saturated        = r_out_sat;
endmodule
`default_nettype wire

// ===== rtl/genotype_emission_accumulator.sv =====
// Top level of the genotype emission accumulator.
// Input channel: i_valid / o_stall carries one base with error and damage
// rates plus start and last flags; an item is taken when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall carries the ten genotype
// scores and the saturation flag, one item per base marked last.
// The user writes score_mode via i_score_mode_we / i_score_mode while idle;
// the block does not enforce it. One item at a time runs on the shared 34x34
// multiplier: setup (LOAD, E3, DOM, DE3, PROB), then per genotype high and
// low products and a fold in product mode, or in log mode the minimum score
// for a zero probability, else a start, normalize shifts (1..31), the bitwise
// log2 squaring loop, an ln2 multiply and an add. A last item then emits.
// The output register holds a finished item; while it is stalled the next
// item is still accepted and processed, waiting only at its own emit.
// Reset (synchronous, active low) sets log mode, zeros all scores and the
// flag, and empties the output register.
`default_nettype none
module genotype_emission_accumulator import gea_pkg::*; #(
    parameter int SCORE_WIDTH    = 32,
    parameter int PROB_FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_score_mode_we,
    input  wire         i_score_mode,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_base_code,
    input  wire  [15:0] i_error_rate,
    input  wire  [15:0] i_damage_g_to_a,
    input  wire  [15:0] i_damage_c_to_t,
    input  wire         i_start_site,
    input  wire         i_last_of_site,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_score_aa,
    output logic [31:0] o_score_cc,
    output logic [31:0] o_score_gg,
    output logic [31:0] o_score_tt,
    output logic [31:0] o_score_ac,
    output logic [31:0] o_score_ag,
    output logic [31:0] o_score_at,
    output logic [31:0] o_score_cg,
    output logic [31:0] o_score_ct,
    output logic [31:0] o_score_gt,
    output logic        o_saturated
);
    t_cmd        cmd;
    t_status     status;
    logic [31:0] score [NGENO];

    gea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gea_datapath #(
        .SCORE_WIDTH    (SCORE_WIDTH),
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_score_mode_we (i_score_mode_we),
        .i_score_mode    (i_score_mode),
        .i_base_code     (i_base_code),
        .i_error_rate    (i_error_rate),
        .i_damage_g_to_a (i_damage_g_to_a),
        .i_damage_c_to_t (i_damage_c_to_t),
        .i_start_site    (i_start_site),
        .i_last_of_site  (i_last_of_site),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_score         (score),
        .o_saturated     (o_saturated)
    );

    assign o_score_aa = score[G_AA];
    assign o_score_cc = score[G_CC];
    assign o_score_gg = score[G_GG];
    assign o_score_tt = score[G_TT];
    assign o_score_ac = score[G_AC];
    assign o_score_ag = score[G_AG];
    assign o_score_at = score[G_AT];
    assign o_score_cg = score[G_CG];
    assign o_score_ct = score[G_CT];
    assign o_score_gt = score[G_GT];
endmodule
`default_nettype wire

// ===== rtl/gea_checker.sv =====
// Port-level checks of the genotype emission accumulator, bound to the top.
`default_nettype none
`include "genotype_emission_accumulator_defines.svh"
module gea_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [31:0] o_score_aa
);
    `GEA_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `GEA_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_score_aa))
    `GEA_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall)
    `GEA_ASSERT_NEXT_ALL(a_reset_empty, !i_rst_n, !o_valid)
endmodule

bind genotype_emission_accumulator gea_checker u_gea_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_score_aa (o_score_aa)
);
`default_nettype wire

// ===== test/genotype_emission_accumulator_checker.sv =====
// Watches both channels, predicts the ten genotype scores and compares results.
`timescale 1ns / 100ps
`default_nettype none
module genotype_emission_accumulator_checker import gea_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_score_mode_we,
    input  wire         i_score_mode,
    input  wire         i_valid,
    input  wire         i_in_stall,
    input  wire  [1:0]  i_base_code,
    input  wire  [15:0] i_error_rate,
    input  wire  [15:0] i_damage_g_to_a,
    input  wire  [15:0] i_damage_c_to_t,
    input  wire         i_start_site,
    input  wire         i_last_of_site,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [31:0] i_score_aa,
    input  wire  [31:0] i_score_cc,
    input  wire  [31:0] i_score_gg,
    input  wire  [31:0] i_score_tt,
    input  wire  [31:0] i_score_ac,
    input  wire  [31:0] i_score_ag,
    input  wire  [31:0] i_score_at,
    input  wire  [31:0] i_score_cg,
    input  wire  [31:0] i_score_ct,
    input  wire  [31:0] i_score_gt,
    input  wire         i_saturated,
    output int          o_errors,
    output int          o_pending
);
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam longint unsigned ONE_P = 64'd65536;

    typedef struct {
        logic [31:0] sc[10];
        logic        sat;
    } t_site_scores;

    longint       geno_score[10];
    bit           sat_seen;
    bit           mode_q;
    t_site_scores site_q[$];

    function automatic longint clamp_sc(longint v);
        if (v > SMAX) begin
            sat_seen = 1'b1;
            return SMAX;
        end
        if (v < SMIN) begin
            sat_seen = 1'b1;
            return SMIN;
        end
        return v;
    endfunction

    function automatic longint mul_fold(longint s, longint unsigned p);
        bit neg;
        longint unsigned m, r;
        neg = s < 0;
        m = neg ? longint'(0) - s : s;
        r = (m >> PQ) * p + (((m & 64'h3FFF_FFFF) * p) >> PQ);
        if (m != 0 && p != 0 && r == 0) sat_seen = 1'b1;
        if (r == 0) return 0;
        if (neg) return -longint'(r - 1) - 1;
        return clamp_sc(longint'(r));
    endfunction

    function automatic longint ln_fix(longint unsigned p);
        int k;
        longint unsigned x, mag, pr;
        longint l2;
        k = 31;
        while (k > 0 && p[k] == 1'b0) k--;
        x = p << (31 - k);
        l2 = longint'(k - PQ) * (longint'(1) << LOG_FRAC);
        for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000) begin
                x = x >> 1;
                l2 += longint'(1) << i;
            end
        end
        mag = (l2 < 0) ? -l2 : l2;
        pr = mag * 64'd2977044472;
        if (l2 < 0) return -longint'((pr + ((64'd1 << 36) - 1)) >> 36);
        return longint'(pr >> 36);
    endfunction

    function automatic void fold_base(logic [1:0] base, longint unsigned e,
                                      longint unsigned ga, longint unsigned ct,
                                      bit st);
        longint unsigned e3, om, half, d, nd, t;
        longint unsigned p[10];
        longint lv;
        e3 = (e << 14) / 3;
        om = (ONE_P - e) << 14;
        half = 64'd1 << 29;
        if (st) begin
            for (int g = 0; g < NGENO; g++) geno_score[g] = mode_q ? 0 : (longint'(1) << PQ);
            sat_seen = 1'b0;
        end
        for (int g = 0; g < NGENO; g++) p[g] = e3;
        d = (base == B_A || base == B_G) ? ga : ct;
        nd = ONE_P - d;
        case (base)
            B_A: begin
                p[G_AA] = om;
                p[G_GG] = (nd * e3 + d * om) >> 16;
                p[G_AC] = half - e3;
                p[G_AG] = ((ONE_P + d) * om + nd * e3) >> 17;
                p[G_AT] = half - e3;
                t = (d * om + (2 * ONE_P - d) * e3) >> 17;
                p[G_CG] = t;
                p[G_GT] = t;
            end
            B_C: begin
                p[G_CC] = (nd * om + d * e3) >> 16;
                t = (nd * om + (ONE_P + d) * e3) >> 17;
                p[G_AC] = t;
                p[G_CG] = t;
                p[G_CT] = t;
            end
            B_G: begin
                p[G_GG] = (nd * om + d * e3) >> 16;
                t = (nd * om + (ONE_P + d) * e3) >> 17;
                p[G_AG] = t;
                p[G_CG] = t;
                p[G_GT] = t;
            end
            default: begin
                p[G_CC] = (nd * e3 + d * om) >> 16;
                p[G_TT] = om;
                p[G_AT] = half - e3;
                t = (d * om + (2 * ONE_P - d) * e3) >> 17;
                p[G_AC] = t;
                p[G_CG] = t;
                p[G_CT] = ((ONE_P + d) * om + nd * e3) >> 17;
                p[G_GT] = half - e3;
            end
        endcase
        for (int g = 0; g < NGENO; g++) begin
            if (!mode_q) begin
                geno_score[g] = mul_fold(geno_score[g], p[g]);
            end else if (p[g] == 0) begin
                geno_score[g] = SMIN;
                sat_seen = 1'b1;
            end else begin
                lv = ln_fix(p[g]);
                if (lv < 0 && geno_score[g] < SMIN - lv) begin
                    sat_seen = 1'b1;
                    geno_score[g] = SMIN;
                end else if (lv > 0 && geno_score[g] > SMAX - lv) begin
                    sat_seen = 1'b1;
                    geno_score[g] = SMAX;
                end else begin
                    geno_score[g] = geno_score[g] + lv;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_site_scores ex, got;
        if (!i_rst_n) begin
            mode_q = 1'b1;
            for (int g = 0; g < NGENO; g++) geno_score[g] = 0;
            sat_seen = 1'b0;
            site_q.delete();
        end else begin
            if (i_score_mode_we) mode_q = i_score_mode;
            if (i_valid && !i_in_stall) begin
                fold_base(i_base_code, i_error_rate, i_damage_g_to_a, i_damage_c_to_t,
                          i_start_site);
                if (i_last_of_site) begin
                    for (int g = 0; g < NGENO; g++) ex.sc[g] = geno_score[g][31:0];
                    ex.sat = sat_seen;
                    site_q.push_back(ex);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got.sc = '{i_score_aa, i_score_cc, i_score_gg, i_score_tt, i_score_ac,
                           i_score_ag, i_score_at, i_score_cg, i_score_ct, i_score_gt};
                got.sat = i_saturated;
                if (site_q.size() == 0) begin
                    $display("%0t unexpected result, none expected", $time);
                    o_errors++;
                end else begin
                    ex = site_q.pop_front();
                    for (int g = 0; g < NGENO; g++)
                        if (got.sc[g] !== ex.sc[g]) begin
                            $display("%0t score %0d mismatch exp %h act %h",
                                     $time, g, ex.sc[g], got.sc[g]);
                            o_errors++;
                        end
                    if (got.sat !== ex.sat) begin
                        $display("%0t saturated mismatch exp %b act %b",
                                 $time, ex.sat, got.sat);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = site_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end
endmodule
`default_nettype wire

// ===== test/genotype_emission_accumulator_tb.sv =====
// Stimulus and verdict for the genotype emission accumulator.
`timescale 1ns / 100ps
`default_nettype none
module genotype_emission_accumulator_tb;
    import gea_pkg::*;

    localparam int WATCH_LIMIT = 20000;
    localparam int SETTLE_CYC  = 800;

    logic        i_clk, i_rst_n, i_score_mode_we, i_score_mode;
    logic        i_valid, i_stall;
    logic [1:0]  i_base_code;
    logic [15:0] i_error_rate, i_damage_g_to_a, i_damage_c_to_t;
    logic        i_start_site, i_last_of_site;
    logic        o_stall, o_valid, o_saturated;
    logic [31:0] o_score_aa, o_score_cc, o_score_gg, o_score_tt, o_score_ac;
    logic [31:0] o_score_ag, o_score_at, o_score_cg, o_score_ct, o_score_gt;
    int          mismatch_cnt, sites_pending, idle_cyc;
    bit          quiet, hold_req;

    genotype_emission_accumulator u_dut (.*);

    genotype_emission_accumulator_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_score_mode_we(i_score_mode_we),
        .i_score_mode(i_score_mode), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_base_code(i_base_code), .i_error_rate(i_error_rate),
        .i_damage_g_to_a(i_damage_g_to_a), .i_damage_c_to_t(i_damage_c_to_t),
        .i_start_site(i_start_site), .i_last_of_site(i_last_of_site),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_score_aa(o_score_aa), .i_score_cc(o_score_cc), .i_score_gg(o_score_gg),
        .i_score_tt(o_score_tt), .i_score_ac(o_score_ac), .i_score_ag(o_score_ag),
        .i_score_at(o_score_at), .i_score_cg(o_score_cg), .i_score_ct(o_score_ct),
        .i_score_gt(o_score_gt), .i_saturated(o_saturated),
        .o_errors(mismatch_cnt), .o_pending(sites_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (3000) @(negedge i_clk);
                i_stall = 1'b0;
                hold_req = 1'b0;
            end else begin
                i_stall = (!quiet && i_rst_n && $urandom_range(99) < 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WATCH_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_base(logic [1:0] b, logic [15:0] e, logic [15:0] ga,
                             logic [15:0] ct, logic st, logic la);
        if (!quiet && $urandom_range(99) < 9)
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        i_base_code = b;
        i_error_rate = e;
        i_damage_g_to_a = ga;
        i_damage_c_to_t = ct;
        i_start_site = st;
        i_last_of_site = la;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (sites_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_mode(logic m);
        wait_idle();
        i_score_mode_we = 1'b1;
        i_score_mode = m;
        @(negedge i_clk);
        i_score_mode_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_sites(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_base(2'($urandom), pick_rate(), pick_rate(), pick_rate(),
                          1'($urandom), 1'($urandom));
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                    send_base(2'($urandom), pick_rate(), pick_rate(), pick_rate(),
                              j == 0, j == len - 1);
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_score_mode_we = 1'b0;
        i_score_mode = 1'b1;
        i_valid = 1'b0;
        i_base_code = '0;
        i_error_rate = '0;
        i_damage_g_to_a = '0;
        i_damage_c_to_t = '0;
        i_start_site = 1'b0;
        i_last_of_site = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // log mode after reset: zero error gives log of zero
        send_base(B_A, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        send_base(B_C, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_base(B_G, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
        send_base(B_T, 16'h0001, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
        // mode change inside a site
        send_base(B_A, 16'h1234, 16'h4321, 16'h0F0F, 1'b1, 1'b0);
        write_mode(1'b0);
        send_base(B_T, 16'h0100, 16'h00FF, 16'hFF00, 1'b0, 1'b1);
        send_base(B_A, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
        send_base(B_C, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
        // product underflow with tiny error
        for (int j = 0; j < 8; j++)
            send_base(B_G, 16'h0001, 16'h0000, 16'h0000, j == 0, j == 7);
        write_mode(1'b1);
        for (int j = 0; j < 6; j++)
            send_base(B_T, 16'h0001, 16'hFFFF, 16'hFFFF, j == 0, j == 5);

        for (int ph = 0; ph < 6; ph++) begin
            write_mode(ph[0] ? 1'b1 : 1'b0);
            quiet = (ph == 2);
            random_sites(ph[0] ? 140 : 260);
            quiet = 1'b0;
            if (ph == 3) begin
                // sender pauses until every result is back
                while (sites_pending != 0) @(negedge i_clk);
            end
        end

        // long receiver hold while items keep coming
        write_mode(1'b0);
        hold_req = 1'b1;
        for (int j = 0; j < 12; j++)
            send_base(2'($urandom), pick_rate(), pick_rate(), pick_rate(), 1'b1, 1'b1);

        while (sites_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (mismatch_cnt == 0 && sites_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ===== genotype_emission_accumulator.f =====
+incdir+rtl
rtl/gea_pkg.sv
rtl/gea_ctrl.sv
rtl/gea_datapath.sv
rtl/genotype_emission_accumulator.sv
rtl/gea_checker.sv
test/genotype_emission_accumulator_checker.sv
test/genotype_emission_accumulator_tb.sv
